@@ rtl/grayscale_reconstruction_by_dilation_assert.svh @@
// ----------------------------------------------------------------------------
// grayscale reconstruction assertion macros
// shared implication checks, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_RECONSTRUCTION_BY_DILATION_ASSERT_SVH
`define GRAYSCALE_RECONSTRUCTION_BY_DILATION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define GRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/grd_pkg.sv @@
// ----------------------------------------------------------------------------
// grd_pkg
// constants, codes and controller/datapath link types
// ----------------------------------------------------------------------------
`default_nettype none

package grd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 16;
    localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(NPIX);
    localparam int CFG_BITS   = 9;
    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 3;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // neighborhood slots visited per pixel
    localparam logic [SLOT_BITS-1:0] SLOT_CENTER = 3'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_LEFT   = 3'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_UP     = 3'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_RIGHT  = 3'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_DOWN   = 3'd4;

    typedef struct packed {
        logic                 load;
        logic                 idx_read;
        logic                 out_read;
        logic                 out_done;
        logic                 sweep_init;
        logic                 slot_cap;
        logic                 pix_write;
        logic [SLOT_BITS-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic last_pix;
        logic any_change;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/grd_in_if.sv @@
// ----------------------------------------------------------------------------
// grd_in_if
// input item channel: function, pixel index, seed and mask
// ----------------------------------------------------------------------------
`default_nettype none

interface grd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] pixel_index;
    logic [15:0] seed_value;
    logic [15:0] mask_value;

    modport source (output valid, func, pixel_index, seed_value, mask_value, input ready);
    modport sink   (input valid, func, pixel_index, seed_value, mask_value, output ready);
endinterface

`default_nettype wire

@@ rtl/grd_out_if.sv @@
// ----------------------------------------------------------------------------
// grd_out_if
// result channel: result kind and pixel value
// ----------------------------------------------------------------------------
`default_nettype none

interface grd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] pixel_value;

    modport source (output valid, result_kind, pixel_value, input ready);
    modport sink   (input valid, result_kind, pixel_value, output ready);
endinterface

`default_nettype wire

@@ rtl/grd_ram.sv @@
// ----------------------------------------------------------------------------
// grd_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module grd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/grd_datapath.sv @@
// ----------------------------------------------------------------------------
// grd_datapath
// pixel stores, raster position, neighborhood accumulate and result register
// ----------------------------------------------------------------------------
`default_nettype none

module grd_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire grd_pkg::t_cmd                 i_cmd,
    output grd_pkg::t_sts                      o_sts,
    input  wire logic [15:0]                   i_pixel_index,
    input  wire logic [15:0]                   i_seed_value,
    input  wire logic [15:0]                   i_mask_value,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [grd_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic                               o_result_kind,
    output logic [15:0]                        o_pixel_value
);
    import grd_pkg::*;

    logic [CFG_BITS-1:0]   r_cfg_w, r_cfg_h;
    logic [CFG_BITS-1:0]   w, h;
    logic [CFG_BITS-1:0]   r_x, r_y;
    logic [ADDR_BITS-1:0]  r_p;
    logic [PIXEL_BITS-1:0] r_v, r_orig, r_m;
    logic                  r_changed;
    logic                  r_oob;
    logic                  r_kind;
    logic [15:0]           r_pix;

    logic [ADDR_BITS-1:0]  idx_a, w_a, nb_addr, raddr, waddr;
    logic                  idx_ok, nb_ok, res_we, last_x, last_y;
    logic [PIXEL_BITS-1:0] res_rd, mask_rd, wdata, cand;

    // out-of-range dimensions fold to the legal range
    always_comb begin
        w = r_cfg_w;
        if (r_cfg_w == '0) begin
            w = CFG_BITS'(1);
        end else if ({1'b0, r_cfg_w} > (CFG_BITS+1)'(MAX_WIDTH)) begin
            w = CFG_BITS'(MAX_WIDTH);
        end
        h = r_cfg_h;
        if (r_cfg_h == '0) begin
            h = CFG_BITS'(1);
        end else if ({1'b0, r_cfg_h} > (CFG_BITS+1)'(MAX_HEIGHT)) begin
            h = CFG_BITS'(MAX_HEIGHT);
        end
    end

    assign idx_a  = i_pixel_index[ADDR_BITS-1:0];
    assign idx_ok = {1'b0, i_pixel_index} < 17'(NPIX);
    assign w_a    = ADDR_BITS'(w);
    assign last_x = (r_x == w - CFG_BITS'(1));
    assign last_y = (r_y == h - CFG_BITS'(1));

    always_comb begin
        nb_addr = r_p;
        nb_ok   = 1'b1;
        unique case (i_cmd.slot)
            SLOT_CENTER: begin
                nb_addr = r_p;
                nb_ok   = 1'b1;
            end
            SLOT_LEFT: begin
                nb_addr = r_p - ADDR_BITS'(1);
                nb_ok   = (r_x != '0);
            end
            SLOT_UP: begin
                nb_addr = r_p - w_a;
                nb_ok   = (r_y != '0);
            end
            SLOT_RIGHT: begin
                nb_addr = r_p + ADDR_BITS'(1);
                nb_ok   = !last_x;
            end
            SLOT_DOWN: begin
                nb_addr = r_p + w_a;
                nb_ok   = !last_y;
            end
            default: begin
                nb_addr = r_p;
                nb_ok   = 1'b0;
            end
        endcase
    end

    // while idle the read port follows the incoming index
    assign raddr  = i_cmd.idx_read ? idx_a : nb_addr;
    assign res_we = (i_cmd.load && idx_ok) || (i_cmd.pix_write && (r_v != r_orig));
    assign waddr  = i_cmd.load ? idx_a : r_p;
    assign wdata  = i_cmd.load ? i_seed_value[PIXEL_BITS-1:0] : r_v;

    grd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(NPIX)) u_result_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (res_rd)
    );

    grd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(NPIX)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && idx_ok),
        .i_waddr (idx_a),
        .i_wdata (i_mask_value[PIXEL_BITS-1:0]),
        .i_raddr (r_p),
        .o_rdata (mask_rd)
    );

    assign cand = (res_rd < r_m) ? res_rd : r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_BITS'(256);
            r_cfg_h <= CFG_BITS'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                default:    r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_p       <= '0;
            r_changed <= 1'b0;
        end else if (i_cmd.sweep_init) begin
            r_x       <= '0;
            r_y       <= '0;
            r_p       <= '0;
            r_changed <= 1'b0;
        end else if (i_cmd.pix_write) begin
            r_changed <= r_changed || (r_v != r_orig);
            r_p       <= r_p + ADDR_BITS'(1);
            if (last_x) begin
                r_x <= '0;
                r_y <= r_y + CFG_BITS'(1);
            end else begin
                r_x <= r_x + CFG_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_cap) begin
            if (i_cmd.slot == SLOT_CENTER) begin
                r_v    <= res_rd;
                r_orig <= res_rd;
                r_m    <= mask_rd;
            end else if (nb_ok && (cand > r_v)) begin
                r_v <= cand;
            end
        end
        if (!i_cmd.load && !i_cmd.out_read) begin
            r_oob <= !idx_ok;
        end
        if (i_cmd.out_read) begin
            r_kind <= KIND_READ;
            r_pix  <= r_oob ? 16'd0 : 16'(res_rd);
        end else if (i_cmd.out_done) begin
            r_kind <= KIND_DONE;
            r_pix  <= 16'd0;
        end
    end

    assign o_sts.last_pix   = last_x && last_y;
    assign o_sts.any_change = r_changed || (r_v != r_orig);
    assign o_result_kind    = r_kind;
    assign o_pixel_value    = r_pix;

endmodule

`default_nettype wire

@@ rtl/grd_ctrl.sv @@
// ----------------------------------------------------------------------------
// grd_ctrl
// item decode and raster sweep sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module grd_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_func,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output grd_pkg::t_cmd    o_cmd,
    input  wire grd_pkg::t_sts i_sts,
    output logic             o_busy
);
    import grd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_CAP    = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.slot  = r_slot;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idx_read = 1'b1;
                if (accept) begin
                    unique case (i_func)
                        FUNC_LOAD:  o_cmd.load = 1'b1;
                        FUNC_START: n_state = S_INIT;
                        FUNC_READ:  n_state = S_RDWAIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RDWAIT: begin
                o_cmd.out_read = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            S_INIT: begin
                o_cmd.sweep_init = 1'b1;
                n_slot           = SLOT_CENTER;
                n_state          = S_ISSUE;
            end
            S_ISSUE: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.slot_cap = 1'b1;
                if (r_slot == SLOT_DOWN) begin
                    n_state = S_WRITE;
                end else begin
                    n_slot  = r_slot + SLOT_BITS'(1);
                    n_state = S_ISSUE;
                end
            end
            S_WRITE: begin
                o_cmd.pix_write = 1'b1;
                n_slot          = SLOT_CENTER;
                if (!i_sts.last_pix) begin
                    n_state = S_ISSUE;
                end else if (i_sts.any_change) begin
                    n_state = S_INIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_done = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= SLOT_CENTER;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_busy      = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/grayscale_reconstruction_by_dilation.sv @@
// ----------------------------------------------------------------------------
// grayscale_reconstruction_by_dilation
// 4-connected grayscale reconstruction by dilation over one image plane
// ----------------------------------------------------------------------------
// Load beats write a seed and mask pixel as the beat is accepted; a read beat
// returns its pixel through the registered memory read and then the output
// register. A start beat runs repeated raster sweeps over the image; after an
// init step, each pixel takes five result-memory reads through the single read
// port, each an issue step and a capture step, then a write-back step; sweeps
// repeat until a sweep changes nothing, then a finished beat is issued. One beat
// is worked on at a time, and no new beat is taken while a result waits on the output.
`default_nettype none

module grayscale_reconstruction_by_dilation (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    grd_in_if.sink                            i_in,
    grd_out_if.source                         o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [grd_pkg::CFG_BITS-1:0] i_cfg_data
);
    import grd_pkg::*;

`include "grayscale_reconstruction_by_dilation_assert.svh"

    t_cmd cmd;
    t_sts sts;
    logic busy;

    grd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_func      (i_in.func),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_busy      (busy)
    );

    grd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel_index (i_in.pixel_index),
        .i_seed_value  (i_in.seed_value),
        .i_mask_value  (i_in.mask_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_result_kind (o_out.result_kind),
        .o_pixel_value (o_out.pixel_value)
    );

    `GRD_ASSERT_SAME(a_busy_blocks_input, i_clk, i_rst_n, busy, !i_in.ready)
    `GRD_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.func == FUNC_START), busy)
    `GRD_ASSERT_NEXT(a_read_gives_data, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.func == FUNC_READ),
        ##1 (o_out.valid && (o_out.result_kind == KIND_READ)))
    `GRD_ASSERT_SAME(a_done_has_zero, i_clk, i_rst_n,
        o_out.valid && (o_out.result_kind == KIND_DONE), o_out.pixel_value == 16'd0)

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for 4-connected grayscale reconstruction by dilation:
// loads, starts and reads are streamed with random gaps on both channels,
// a behavioral image model predicts every read pixel and finished beat
// ----------------------------------------------------------------------------

module tb_top;
    import grd_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] idx;
        logic [15:0] seed;
        logic [15:0] mask;
    } t_beat;

    typedef struct {
        logic        kind;
        logic [15:0] value;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;

    grd_in_if  in_ch();
    grd_out_if out_ch();

    grayscale_reconstruction_by_dilation uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // image model state
    logic [15:0] img_result[NPIX];
    logic [15:0] img_mask[NPIX];
    int unsigned img_w;
    int unsigned img_h;

    t_beat   pending_beats[$];
    t_result expected_pixels[$];
    t_beat   held_beat;
    int      fail_count;
    int      results_seen;
    int      hold_left;
    int      stall_count;
    bit      no_gaps;

    // used only by stimulus generation
    bit          written_pix[NPIX];
    logic [15:0] extra_written[$];
    int          items_sent;

    always #4 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 1) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return v;
    endfunction

    function automatic logic [15:0] min16(logic [15:0] a, logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    // iterate raster relaxation until nothing rises; fixed point is order independent
    function automatic void reconstruct_image();
        int unsigned n;
        int unsigned p;
        int unsigned x;
        logic [15:0] v;
        logic [15:0] m;
        logic [15:0] t;
        bit changed;
        n = img_w * img_h;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (p = 0; p < n; p++) begin
                x = p % img_w;
                v = img_result[p];
                m = img_mask[p];
                if (x > 0) begin t = min16(img_result[p-1], m); if (t > v) v = t; end
                if (x + 1 < img_w) begin t = min16(img_result[p+1], m); if (t > v) v = t; end
                if (p >= img_w) begin t = min16(img_result[p-img_w], m); if (t > v) v = t; end
                if (p + img_w < n) begin t = min16(img_result[p+img_w], m); if (t > v) v = t; end
                if (v != img_result[p]) begin
                    img_result[p] = v;
                    changed = 1'b1;
                end
            end
        end
    endfunction

    function automatic void apply_beat(t_beat b);
        t_result r;
        case (b.func)
            FUNC_LOAD: begin
                img_result[b.idx] = b.seed;
                img_mask[b.idx]   = b.mask;
            end
            FUNC_START: begin
                reconstruct_image();
                r.kind = KIND_DONE;
                r.value = 16'd0;
                expected_pixels.push_back(r);
            end
            FUNC_READ: begin
                r.kind = KIND_READ;
                r.value = img_result[b.idx];
                expected_pixels.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) apply_beat(held_beat);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_beats.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 8)) begin
                    held_beat = pending_beats.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.func        <= held_beat.func;
                    in_ch.pixel_index <= held_beat.idx;
                    in_ch.seed_value  <= held_beat.seed;
                    in_ch.mask_value  <= held_beat.mask;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen = results_seen + 1;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d value=%h", $realtime,
                             out_ch.result_kind, out_ch.pixel_value);
                    fail_count++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (out_ch.result_kind !== e.kind) begin
                        $display("%0t: result_kind expected %0d actual %0d", $realtime,
                                 e.kind, out_ch.result_kind);
                        fail_count++;
                    end
                    if (out_ch.pixel_value !== e.value) begin
                        $display("%0t: pixel_value expected %h actual %h", $realtime,
                                 e.value, out_ch.pixel_value);
                        fail_count++;
                    end
                end
                // long back-pressure so the block backs up into its input
                if (results_seen == 30) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send(logic [1:0] func, logic [15:0] idx, logic [15:0] seed,
                        logic [15:0] mask);
        t_beat b;
        b.func = func;
        b.idx  = idx;
        b.seed = seed;
        b.mask = mask;
        if (func == FUNC_LOAD) begin
            if (!written_pix[idx]) extra_written.push_back(idx);
            written_pix[idx] = 1'b1;
        end
        pending_beats.push_back(b);
        items_sent++;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(int unsigned w_raw, int unsigned h_raw);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= w_raw[CFG_BITS-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= h_raw[CFG_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        img_w = clamp_dim(w_raw);
        img_h = clamp_dim(h_raw);
    endtask

    // flat image: seed equals mask, so nothing propagates and sweeps stay few
    task automatic load_image(bit flat);
        int unsigned p;
        logic [15:0] s;
        for (p = 0; p < img_w * img_h; p++) begin
            s = $urandom;
            send(FUNC_LOAD, p[15:0], s, flat ? s : 16'($urandom));
        end
    endtask

    task automatic random_phase(int unsigned ops);
        int unsigned k;
        int unsigned sel;
        int unsigned n;
        logic [15:0] idx;
        n = img_w * img_h;
        load_image(1'b0);
        for (k = 0; k < ops; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                send(FUNC_READ, 16'($urandom_range(0, n - 1)), 16'($urandom), 16'($urandom));
            end else if (sel < 65) begin
                send(FUNC_LOAD, 16'($urandom_range(0, n - 1)), 16'($urandom), 16'($urandom));
            end else if (sel < 75) begin
                send(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (sel < 88) begin
                send(FUNC_START, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (sel < 93) begin
                send(FUNC_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                idx = extra_written[$urandom_range(0, extra_written.size() - 1)];
                send(FUNC_READ, idx, 16'($urandom), 16'($urandom));
            end
        end
        send(FUNC_START, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < 4; k++)
            send(FUNC_READ, 16'($urandom_range(0, n - 1)), 16'd0, 16'd0);
    endtask

    initial begin
        int unsigned k;
        i_clk             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_LOAD;
        in_ch.pixel_index = 16'd0;
        in_ch.seed_value  = 16'd0;
        in_ch.mask_value  = 16'd0;
        out_ch.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_WIDTH;
        i_cfg_data        = '0;
        fail_count        = 0;
        results_seen      = 0;
        hold_left         = 0;
        stall_count       = 0;
        no_gaps           = 1'b0;
        items_sent        = 0;
        img_w             = MAX_WIDTH;
        img_h             = MAX_HEIGHT;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero dims act as 1x1; seed above mask stays; top index; unused func
        set_dims(0, 0);
        send(FUNC_LOAD, 16'd0, 16'hFFFF, 16'h0000);
        send(FUNC_LOAD, 16'hFFFF, 16'h0000, 16'hFFFF);
        send(FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_READ, 16'd0, 16'd0, 16'd0);
        send(FUNC_START, 16'd0, 16'd0, 16'd0);
        send(FUNC_READ, 16'd0, 16'd0, 16'd0);
        send(FUNC_READ, 16'hFFFF, 16'd0, 16'd0);

        // 2x2: pixel outside the image keeps its value through a start
        set_dims(2, 2);
        send(FUNC_LOAD, 16'd0, 16'h8000, 16'hFFFF);
        send(FUNC_LOAD, 16'd1, 16'h0000, 16'h7FFF);
        send(FUNC_LOAD, 16'd2, 16'h0000, 16'hFFFF);
        send(FUNC_LOAD, 16'd3, 16'h0001, 16'h0000);
        send(FUNC_LOAD, 16'd4, 16'h0000, 16'hFFFF);
        send(FUNC_START, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < 5; k++) send(FUNC_READ, k[15:0], 16'd0, 16'd0);

        // widest row (over-range width clamps) and tallest column, flat content
        set_dims(511, 1);
        load_image(1'b1);
        send(FUNC_LOAD, 16'd255, 16'h0000, 16'hFFFF);
        send(FUNC_LOAD, 16'd254, 16'hFFFF, 16'hFFFF);
        send(FUNC_START, 16'd0, 16'd0, 16'd0);
        send(FUNC_READ, 16'd255, 16'd0, 16'd0);
        send(FUNC_READ, 16'd0, 16'd0, 16'd0);
        set_dims(1, 256);
        load_image(1'b1);
        send(FUNC_LOAD, 16'd0, 16'h0000, 16'hFFFF);
        send(FUNC_START, 16'd0, 16'd0, 16'd0);
        send(FUNC_READ, 16'd0, 16'd0, 16'd0);
        send(FUNC_READ, 16'd255, 16'd0, 16'd0);

        k = 0;
        while (items_sent < 850) begin
            set_dims($urandom_range(1, 8), $urandom_range(1, 8));
            no_gaps = (k == 1);
            random_phase($urandom_range(20, 50));
            k++;
        end

        wait_idle();
        no_gaps = 1'b0;
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
